/* rtl/lts_pkg.sv */
// ----------------------------------------------------------------------------
// lts_pkg
// shared types for the streaming longest increasing subsequence length block
// ----------------------------------------------------------------------------
package lts_pkg;

    // width of the reported length field
    localparam int OUT_W = 11;

    typedef struct packed {
        logic signed [31:0] sample_value;
        logic               start_seq;
    } sample_t;

    typedef struct packed {
        logic [OUT_W-1:0] lis_length;
        logic             overflow;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_COMPARE,
        ST_FINISH
    } lts_state_t;

endpackage

/* rtl/lis_length_tail_search.sv */
// ----------------------------------------------------------------------------
// lis_length_tail_search
// streaming length of the longest strictly increasing subsequence
// ----------------------------------------------------------------------------
// Each sample transfer updates a memory of smallest tail values, one per
// subsequence length, and yields one result transfer with the length so far
// (modulo 2048) and an overflow flag. A start flag, or the first sample after
// reset, restarts the sequence at length one. A sample above the largest tail
// (held in a register) extends the length; if the memory is already full the
// length stays at MAX_LEN and overflow is set for that result. Any other
// sample replaces the first tail greater than or equal to it, found by a
// binary search through the single read port of the tail memory. Each search
// step is one registered memory read in ST_SEARCH plus one compare in
// ST_COMPARE; an item that restarts or extends goes straight to ST_FINISH,
// any other one steps through the search until its range holds one entry.
// One item is worked on at a time; sample_stall stays high until its result is
// in the output register, and the next sample transfer can proceed while that
// result still waits for the consumer. The tail memory needs no clearing after
// reset: only entries below the current length are ever read.
module lis_length_tail_search #(
    parameter int MAX_LEN = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  lts_pkg::sample_t  sample,
    output logic              result_valid,
    input  logic              result_stall,
    output lts_pkg::result_t  result
);
    import lts_pkg::*;

    // index width into the tail memory and width of the length counter
    localparam int AW = $clog2(MAX_LEN);
    localparam int LW = $clog2(MAX_LEN + 1);

    // tail memory, one write and one registered read port
    logic signed [31:0] tail_mem [MAX_LEN];
    logic signed [31:0] rd_data_reg;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic signed [31:0] mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;

    // sequencer state
    lts_state_t         state_reg, state_next;
    logic [LW-1:0]      len_reg, len_next;
    logic signed [31:0] last_reg, last_next;     // largest tail
    logic signed [31:0] value_reg, value_next;   // sample being placed
    logic               ovf_reg, ovf_next;
    logic [AW-1:0]      lo_reg, lo_next;
    logic [AW-1:0]      hi_reg, hi_next;
    logic [AW-1:0]      mid_reg, mid_next;
    logic [AW-1:0]      mid_calc;
    logic [AW-1:0]      top_index;               // index of the largest tail

    // output register
    logic               result_valid_reg, result_valid_next;
    result_t            result_reg, result_next;
    logic               result_load;

    // length masked to the output field width
    logic [LW+OUT_W-1:0] len_wide;
    logic [OUT_W-1:0]    len_out;

    assign len_wide  = {{OUT_W{1'b0}}, len_reg};
    assign len_out   = len_wide[OUT_W-1:0];
    assign top_index = AW'(len_reg - LW'(1));
    assign mid_calc  = lo_reg + ((hi_reg - lo_reg) >> 1);

    assign sample_stall = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // tail memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tail_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= tail_mem[mem_raddr];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            len_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            len_reg          <= len_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // working registers, no reset needed
    always_ff @(posedge clk)
    begin
        last_reg   <= last_next;
        value_reg  <= value_next;
        ovf_reg    <= ovf_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        result_reg <= result_next;
    end

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        len_next          = len_reg;
        last_next         = last_reg;
        value_next        = value_reg;
        ovf_next          = ovf_reg;
        lo_next           = lo_reg;
        hi_next           = hi_reg;
        mid_next          = mid_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;
        result_load       = 1'b0;
        mem_we            = 1'b0;
        mem_waddr         = lo_reg;
        mem_wdata         = value_reg;
        mem_re            = 1'b0;
        mem_raddr         = mid_calc;

        // consumer takes the waiting result
        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    value_next = sample.sample_value;
                    ovf_next   = 1'b0;
                    if (sample.start_seq || (len_reg == '0))
                    begin
                        // new sequence
                        mem_we     = 1'b1;
                        mem_waddr  = '0;
                        mem_wdata  = sample.sample_value;
                        len_next   = LW'(1);
                        last_next  = sample.sample_value;
                        state_next = ST_FINISH;
                    end
                    else if (sample.sample_value > last_reg)
                    begin
                        if (len_reg < LW'(MAX_LEN))
                        begin
                            // extend by one
                            mem_we    = 1'b1;
                            mem_waddr = AW'(len_reg);
                            mem_wdata = sample.sample_value;
                            len_next  = len_reg + LW'(1);
                            last_next = sample.sample_value;
                        end
                        else
                        begin
                            // store full, drop and flag
                            ovf_next = 1'b1;
                        end
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        lo_next    = '0;
                        hi_next    = top_index;
                        state_next = ST_SEARCH;
                    end
                end
            end

            ST_SEARCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    mem_re     = 1'b1;
                    mid_next   = mid_calc;
                    state_next = ST_COMPARE;
                end
                else
                begin
                    // replace the first tail not below the sample
                    mem_we = 1'b1;
                    if (lo_reg == top_index)
                    begin
                        last_next = value_reg;
                    end
                    state_next = ST_FINISH;
                end
            end

            ST_COMPARE:
            begin
                if (rd_data_reg >= value_reg)
                begin
                    hi_next = mid_reg;
                end
                else
                begin
                    lo_next = mid_reg + AW'(1);
                end
                state_next = ST_SEARCH;
            end

            ST_FINISH:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_load = 1'b1;
                    state_next  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (result_load)
        begin
            result_next.lis_length = len_out;
            result_next.overflow   = ovf_reg;
            result_valid_next      = 1'b1;
        end
    end

    // length never passes the memory depth
    assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LW'(MAX_LEN))
        else $error("length above memory depth");

    // a search only runs with a nonempty store and an ordered range
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH || state_reg == ST_COMPARE)
            |-> (len_reg != '0) && (lo_reg <= hi_reg) && (hi_reg <= top_index))
        else $error("search range out of order");

    // an accepted sample keeps the block busy in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && !sample_stall) |=> (state_reg != ST_IDLE))
        else $error("sample accepted without work");

    // overflow is only reported with a saturated store
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_load && ovf_reg) |-> (len_reg == LW'(MAX_LEN)))
        else $error("overflow below full length");

endmodule
